// ===== sv/sequence_replay_window_assert.svh =====
// assertion macros shared by the replay window rtl
`ifndef SEQUENCE_REPLAY_WINDOW_ASSERT_SVH
`define SEQUENCE_REPLAY_WINDOW_ASSERT_SVH

// clocked check, off while reset is asserted
`define SRW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked implication checked in the next cycle, off while reset is asserted
`define SRW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/srw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srw_pkg;

	localparam int WINDOW_BITS = 64;
	localparam int CLASS_COUNT = 2;

	localparam int SEQ_W = 64;
	localparam int SH_W  = $clog2(WINDOW_BITS);
	localparam int CLS_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

	typedef enum logic [2:0] {
		VERDICT_ZERO      = 3'd0,
		VERDICT_FIRST     = 3'd1,
		VERDICT_ADVANCED  = 3'd2,
		VERDICT_IN_WINDOW = 3'd3,
		VERDICT_TOO_OLD   = 3'd4,
		VERDICT_DUPLICATE = 3'd5
	} verdict_t;

	typedef logic [WINDOW_BITS-1:0] map_t;

endpackage

`default_nettype wire

// ===== sv/sequence_replay_window.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | handshake                  | payload
// ---------+-----+----------------------------+-------------------------------------
// s_*      | in  | s_tvalid / s_tready        | tdata: sequence_number, tuser: class
// m_*      | out | m_tvalid / m_tready        | tdata: accepted, verdict
//
// one transaction per cycle sustained while m_tready allows; a result passes from the input
// register, then through check and window update into the result register.
// the check is 64-bit compares and subtracts and a map shift, all in the input stage.
// arst_n clears both windows (highest and map) and the valid flags at once.
// a stall on m_tready holds the result; the input stage keeps accepting while it is empty,
// or while the result register is empty or being taken in the same cycle.

`include "sequence_replay_window_assert.svh"

module sequence_replay_window (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // [63:0] sequence_number
	input  wire logic        s_tuser,  // [0] traffic_class
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata   // [0] accepted, [3:1] verdict, [7:4] zero
);

	localparam int CMP_W = srw_pkg::CLS_W + 1;

	logic                         valid_s1;
	logic [srw_pkg::SEQ_W-1:0]    seq_s1;
	logic [srw_pkg::CLS_W-1:0]    idx_s1;

	logic                         valid_s2;
	logic                         accepted_s2;
	srw_pkg::verdict_t            verdict_s2;

	logic [srw_pkg::SEQ_W-1:0]    highest_q [srw_pkg::CLASS_COUNT];
	srw_pkg::map_t                map_q     [srw_pkg::CLASS_COUNT];

	logic                         advance;
	logic                         fire;
	logic [CMP_W-1:0]             tc_ext;
	logic [srw_pkg::CLS_W-1:0]    idx_in;

	logic [srw_pkg::SEQ_W-1:0]    top_c;
	srw_pkg::map_t                map_c;
	logic [srw_pkg::SEQ_W-1:0]    gap_c;
	logic [srw_pkg::SEQ_W-1:0]    age_c;
	logic [srw_pkg::SEQ_W-1:0]    new_top_c;
	srw_pkg::map_t                new_map_c;
	logic                         wr_c;
	srw_pkg::verdict_t            verdict_c;
	logic                         accepted_c;

	assign advance  = !valid_s2 || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// classes beyond the count fold onto the last window
	always_comb begin
		tc_ext = CMP_W'(s_tuser);
		if (tc_ext >= CMP_W'(srw_pkg::CLASS_COUNT)) begin
			idx_in = srw_pkg::CLS_W'(srw_pkg::CLASS_COUNT - 1);
		end else begin
			idx_in = tc_ext[srw_pkg::CLS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			seq_s1 <= s_tdata;
			idx_s1 <= idx_in;
		end
	end

	assign top_c = highest_q[idx_s1];
	assign map_c = map_q[idx_s1];
	assign gap_c = seq_s1 - top_c;
	assign age_c = top_c - seq_s1;

	always_comb begin
		verdict_c = srw_pkg::VERDICT_ZERO;
		wr_c      = 1'b0;
		new_top_c = top_c;
		new_map_c = map_c;
		priority if (seq_s1 == '0) begin
			verdict_c = srw_pkg::VERDICT_ZERO;
		end else if (top_c == '0) begin
			verdict_c = srw_pkg::VERDICT_FIRST;
			wr_c      = 1'b1;
			new_top_c = seq_s1;
			new_map_c = srw_pkg::map_t'(1);
		end else if (seq_s1 > top_c) begin
			verdict_c = srw_pkg::VERDICT_ADVANCED;
			wr_c      = 1'b1;
			new_top_c = seq_s1;
			if (gap_c >= srw_pkg::SEQ_W'(srw_pkg::WINDOW_BITS)) begin
				new_map_c = srw_pkg::map_t'(1);
			end else begin
				new_map_c = (map_c << gap_c[srw_pkg::SH_W-1:0]) | srw_pkg::map_t'(1);
			end
		end else if (age_c >= srw_pkg::SEQ_W'(srw_pkg::WINDOW_BITS)) begin
			verdict_c = srw_pkg::VERDICT_TOO_OLD;
		end else if (map_c[age_c[srw_pkg::SH_W-1:0]]) begin
			verdict_c = srw_pkg::VERDICT_DUPLICATE;
		end else begin
			verdict_c = srw_pkg::VERDICT_IN_WINDOW;
			wr_c      = 1'b1;
			new_map_c = map_c | (srw_pkg::map_t'(1) << age_c[srw_pkg::SH_W-1:0]);
		end
	end

	assign accepted_c = (verdict_c == srw_pkg::VERDICT_FIRST) ||
		(verdict_c == srw_pkg::VERDICT_ADVANCED) ||
		(verdict_c == srw_pkg::VERDICT_IN_WINDOW);

	// window state moves with the transaction leaving the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < srw_pkg::CLASS_COUNT; i++) begin
				highest_q[i] <= '0;
				map_q[i]     <= '0;
			end
		end else if (fire && wr_c) begin
			highest_q[idx_s1] <= new_top_c;
			map_q[idx_s1]     <= new_map_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			accepted_s2 <= accepted_c;
			verdict_s2  <= verdict_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, verdict_s2, accepted_s2};

	`SRW_ASSERT_NEXT(a_adv_sets_top, fire && wr_c && (verdict_c != srw_pkg::VERDICT_IN_WINDOW),
		highest_q[$past(idx_s1)] == $past(seq_s1), "advance did not record sequence")

	for (genvar g = 0; g < srw_pkg::CLASS_COUNT; g++) begin : g_win_chk
		`SRW_ASSERT(a_top_bit_set, (highest_q[g] == '0) || map_q[g][0],
			"live window lost its top bit")
		`SRW_ASSERT(a_empty_map, (highest_q[g] != '0) || (map_q[g] == '0),
			"empty window has map bits")
		`SRW_ASSERT_NEXT(a_reject_keeps, fire && !accepted_c,
			$stable(highest_q[g]) && $stable(map_q[g]), "rejected transaction changed window")
	end

endmodule

`default_nettype wire

// ===== verif/tb_sequence_replay_window.sv =====
`timescale 1ns / 1ps

module tb_sequence_replay_window;

	typedef struct packed {
		logic [srw_pkg::SEQ_W-1:0] seq;
		logic                      cls;
	} packet_t;

	typedef struct packed {
		logic              accepted;
		srw_pkg::verdict_t verdict;
	} verdict_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;  // [63:0] sequence_number
	logic        s_tuser = 1'b0;  // [0] traffic_class
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;  // [0] accepted, [3:1] verdict, [7:4] zero

	packet_t       packet_queue[$];
	verdict_item_t verdict_queue[$];

	// window state as the block should hold it
	logic [srw_pkg::SEQ_W-1:0] win_top[srw_pkg::CLASS_COUNT];
	srw_pkg::map_t             win_map[srw_pkg::CLASS_COUNT];
	// highest nonzero sequence queued so far, per class, to steer the stimulus
	logic [srw_pkg::SEQ_W-1:0] gen_top[srw_pkg::CLASS_COUNT];

	logic in_taken = 1'b0;
	int   src_gap = 0;
	int   snk_gap = 0;
	int   errors = 0;
	logic quiet;

	sequence_replay_window u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// no idling near the end of the run
	assign quiet = (packet_queue.size() < 80);

	function automatic srw_pkg::verdict_t judge_sequence(int unsigned cls_in,
		logic [srw_pkg::SEQ_W-1:0] seq);
		int unsigned               cls;
		logic [srw_pkg::SEQ_W-1:0] top;
		logic [srw_pkg::SEQ_W-1:0] gap;
		srw_pkg::map_t             map;
		srw_pkg::map_t             bit_at;
		cls = (cls_in >= srw_pkg::CLASS_COUNT) ? srw_pkg::CLASS_COUNT - 1 : cls_in;
		top = win_top[cls];
		map = win_map[cls];
		if (seq == '0)
			return srw_pkg::VERDICT_ZERO;
		if (top == '0) begin
			win_top[cls] = seq;
			win_map[cls] = srw_pkg::map_t'(1);
			return srw_pkg::VERDICT_FIRST;
		end
		if (seq > top) begin
			gap = seq - top;
			if (gap >= srw_pkg::WINDOW_BITS)
				map = srw_pkg::map_t'(1);
			else
				map = (map << gap) | srw_pkg::map_t'(1);
			win_map[cls] = map;
			win_top[cls] = seq;
			return srw_pkg::VERDICT_ADVANCED;
		end
		gap = top - seq;
		if (gap >= srw_pkg::WINDOW_BITS)
			return srw_pkg::VERDICT_TOO_OLD;
		bit_at = srw_pkg::map_t'(1) << gap;
		if ((map & bit_at) != '0)
			return srw_pkg::VERDICT_DUPLICATE;
		win_map[cls] = map | bit_at;
		return srw_pkg::VERDICT_IN_WINDOW;
	endfunction

	task automatic queue_packet(logic [srw_pkg::SEQ_W-1:0] seq, logic cls);
		packet_t p;
		p.seq = seq;
		p.cls = cls;
		packet_queue.push_back(p);
		if (seq > gen_top[cls])
			gen_top[cls] = seq;
	endtask

	task automatic queue_random_packet();
		logic                      cls;
		logic [srw_pkg::SEQ_W-1:0] top;
		logic [srw_pkg::SEQ_W-1:0] seq;
		logic [srw_pkg::SEQ_W-1:0] jump;
		int                        kind;
		cls = 1'($urandom_range(0, 1));
		top = gen_top[cls];
		kind = $urandom_range(0, 99);
		if (top == '0)
			seq = srw_pkg::SEQ_W'($urandom_range(1, 1000));
		else if (kind < 40)
			seq = top + srw_pkg::SEQ_W'($urandom_range(1, 70));
		else if (kind < 72)
			seq = top - srw_pkg::SEQ_W'($urandom_range(0, 63));
		else if (kind < 84)
			seq = top - srw_pkg::SEQ_W'($urandom_range(64, 200)) -
				srw_pkg::SEQ_W'($urandom_range(0, 3) << 20);
		else if (kind < 91) begin
			jump = {$urandom, $urandom} >> $urandom_range(8, 63);
			seq = top + jump;
			if (seq <= top)
				seq = top - srw_pkg::SEQ_W'($urandom_range(0, 63));
		end else if (kind < 97)
			seq = '0;
		else
			seq = {$urandom, $urandom};
		queue_packet(seq, cls);
	endtask

	// source side: hold the transaction until taken, random gaps between items
	always @(posedge clk) begin
		in_taken <= s_tvalid && s_tready;
	end

	always @(negedge clk) begin
		packet_t p;
		if (arst_n) begin
			if (!(s_tvalid && !in_taken)) begin
				if (src_gap == 0 && !quiet && $urandom_range(0, 11) == 0)
					src_gap = $urandom_range(1, 18);
				if (src_gap > 0) begin
					src_gap = src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (packet_queue.size() > 0) begin
					p = packet_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= p.seq;
					s_tuser <= p.cls;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (snk_gap == 0 && !quiet && $urandom_range(0, 11) == 0)
				snk_gap = $urandom_range(1, 18);
			if (snk_gap > 0) begin
				snk_gap = snk_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// predict on every accepted input transaction
	always @(posedge clk) begin
		verdict_item_t e;
		if (arst_n && s_tvalid && s_tready) begin
			e.verdict = judge_sequence(int'(s_tuser), s_tdata);
			e.accepted = (e.verdict == srw_pkg::VERDICT_FIRST ||
				e.verdict == srw_pkg::VERDICT_ADVANCED ||
				e.verdict == srw_pkg::VERDICT_IN_WINDOW);
			verdict_queue.push_back(e);
		end
	end

	// compare every result transaction with the oldest prediction
	always @(posedge clk) begin
		verdict_item_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_queue.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				errors = errors + 1;
			end else begin
				e = verdict_queue.pop_front();
				if (m_tdata[0] !== e.accepted) begin
					$display("%0t: accepted mismatch, expected %0d, actual %0d",
						$time, e.accepted, m_tdata[0]);
					errors = errors + 1;
				end
				if (m_tdata[3:1] !== e.verdict) begin
					$display("%0t: verdict mismatch, expected %0d, actual %0d",
						$time, e.verdict, m_tdata[3:1]);
					errors = errors + 1;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < srw_pkg::CLASS_COUNT; i++) begin
			win_top[i] = '0;
			win_map[i] = '0;
			gen_top[i] = '0;
		end

		// unreliable window: zero, first, duplicate of the top, window edges
		queue_packet(64'd0, 1'b0);
		queue_packet(64'd100, 1'b0);
		queue_packet(64'd100, 1'b0);
		queue_packet(64'd37, 1'b0);
		queue_packet(64'd36, 1'b0);
		queue_packet(64'd37, 1'b0);
		queue_packet(64'd99, 1'b0);
		queue_packet(64'd0, 1'b0);
		queue_packet(64'd163, 1'b0);
		queue_packet(64'd227, 1'b0);
		queue_packet(64'd226, 1'b0);
		queue_packet(64'd164, 1'b0);
		queue_packet(64'd163, 1'b0);
		// reliable window: zero on empty, first, huge jump, far too old
		queue_packet(64'd0, 1'b1);
		queue_packet(64'd5, 1'b1);
		queue_packet(64'h8000_0000_0000_0005, 1'b1);
		queue_packet(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
		queue_packet(64'd6, 1'b1);
		queue_packet(64'h8000_0000_0000_0004, 1'b1);

		for (int i = 0; i < 850; i++)
			queue_random_packet();

		// top of the sequence space, once no further advance is needed
		for (int c = 0; c < 2; c++) begin
			queue_packet(64'hFFFF_FFFF_FFFF_FFFF, 1'(c));
			queue_packet(64'hFFFF_FFFF_FFFF_FFFE, 1'(c));
			queue_packet(64'hFFFF_FFFF_FFFF_FFFF, 1'(c));
			queue_packet(64'hFFFF_FFFF_FFFF_FFBF, 1'(c));
			queue_packet(64'hFFFF_FFFF_FFFF_FFC0, 1'(c));
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (packet_queue.size() != 0 || s_tvalid || verdict_queue.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
